FILE: rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants of the homogeneous point transform
// Register indexes and the control word that travels beside the datapath.
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;

    localparam logic [2:0] REG_R0C01 = 3'd0;
    localparam logic [2:0] REG_R0C23 = 3'd1;
    localparam logic [2:0] REG_R1C01 = 3'd2;
    localparam logic [2:0] REG_R1C23 = 3'd3;
    localparam logic [2:0] REG_R2C01 = 3'd4;
    localparam logic [2:0] REG_R2C23 = 3'd5;
    localparam logic [2:0] REG_R3C01 = 3'd6;
    localparam logic [2:0] REG_R3C23 = 3'd7;

    // per-stage control carried next to the data
    typedef struct packed {
        logic valid;
        logic w_zero;
    } stage_ctl_t;

endpackage

FILE: rtl/core/homogeneous_point_transform_top.sv
// Path from input word to result word: product registers, column sum, divider
// entry, one register per quotient bit, output register.
// Throughput: one word per cycle; the whole pipeline advances on one enable,
// stalling only when the output register is full and not taken.
// Reset (aresetn, synchronous, active low): matrix returns to identity and
// all valid bits clear.
// ----------------------------------------------------------------------------
// homogeneous_point_transform_top: point times 4x4 matrix, perspective divide
// Four column lanes, three divider lanes, APB register file, output register.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpt_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [hpt_pkg::DATA_BITS-1:0]       pwdata,
    output logic [hpt_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_point_x,
    input  logic signed [31:0]                  s_point_y,
    input  logic signed [31:0]                  s_point_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_out_x,
    output logic signed [31:0]                  m_out_y,
    output logic signed [31:0]                  m_out_z,
    output logic                                m_w_zero
);
    import hpt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int DS  = CW + FB;      // divider stages after its input reg
    localparam int NST = DS + 2;       // product, column, divider entry, steps

    logic [DATA_BITS-1:0] regs_reg [0:NUM_REGS-1];
    logic [2:0] widx;
    logic adv;

    assign pready = 1'b1;
    assign widx   = paddr[5:3];

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg[REG_R0C01] <= 64'(1) << FB;
            regs_reg[REG_R0C23] <= 64'd0;
            regs_reg[REG_R1C01] <= (64'(1) << FB) << 32;
            regs_reg[REG_R1C23] <= 64'd0;
            regs_reg[REG_R2C01] <= 64'd0;
            regs_reg[REG_R2C23] <= 64'(1) << FB;
            regs_reg[REG_R3C01] <= 64'd0;
            regs_reg[REG_R3C23] <= (64'(1) << FB) << 32;
        end else if (psel && penable && pwrite) begin
            regs_reg[widx] <= pwdata;
        end
    end
    assign prdata = regs_reg[widx];

    // pipeline valid bits; everything advances together
    stage_ctl_t ctl_reg [0:NST];
    logic out_valid_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic owz_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // matrix entries, sign extended from CW bits
    logic signed [CW-1:0] m [0:3][0:3];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            m[r][0] = regs_reg[2*r][CW-1:0];
            m[r][1] = regs_reg[2*r][32+CW-1:32];
            m[r][2] = regs_reg[2*r+1][CW-1:0];
            m[r][3] = regs_reg[2*r+1][32+CW-1:32];
        end
    end

    // column lanes
    logic signed [CW-1:0] col [0:3];
    genvar gc;
    generate
        for (gc = 0; gc < 4; gc++) begin : g_col
            hpt_col #(.CW(CW), .FB(FB)) u_col (
                .aclk(aclk), .en0(adv), .en1(adv),
                .x(s_point_x[CW-1:0]), .y(s_point_y[CW-1:0]), .z(s_point_z[CW-1:0]),
                .m0(m[0][gc]), .m1(m[1][gc]), .m2(m[2][gc]), .m3(m[3][gc]),
                .col_reg(col[gc])
            );
        end
    endgenerate

    // w classification feeds the divider lanes
    logic w_zero_c, w_one_c;
    assign w_zero_c = (col[3] == '0);
    assign w_one_c  = (col[3] == CW'(1 << FB));

    logic signed [CW-1:0] q [0:2];
    generate
        for (gc = 0; gc < 3; gc++) begin : g_div
            hpt_div #(.CW(CW), .FB(FB)) u_div (
                .aclk(aclk), .en({(DS+1){adv}}),
                .num(col[gc]), .den(w_zero_c ? CW'(1) : col[3]),
                .bypass(w_one_c), .q_out(q[gc])
            );
        end
    endgenerate

    // control shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NST; i++) ctl_reg[i] <= '0;
        end else if (adv) begin
            ctl_reg[0] <= '{valid: s_valid, w_zero: 1'b0};
            ctl_reg[1] <= ctl_reg[0];
            ctl_reg[2] <= '{valid: ctl_reg[1].valid, w_zero: w_zero_c};
            for (int i = 3; i <= NST; i++) ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    // output register: merge lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= ctl_reg[NST].valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            owz_reg <= ctl_reg[NST].w_zero;
            ox_reg  <= ctl_reg[NST].w_zero ? 32'sd0 : 32'(q[0]);
            oy_reg  <= ctl_reg[NST].w_zero ? 32'sd0 : 32'(q[1]);
            oz_reg  <= ctl_reg[NST].w_zero ? 32'sd0 : 32'(q[2]);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_out_x  = ox_reg;
    assign m_out_y  = oy_reg;
    assign m_out_z  = oz_reg;
    assign m_w_zero = owz_reg;
endmodule

FILE: rtl/core/hpt_col.sv
// ----------------------------------------------------------------------------
// hpt_col: one matrix column lane
// Three products (registered), then floor shift, sum with translation, saturate.
// ----------------------------------------------------------------------------
module hpt_col #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 aclk,
    input  logic                 en0,
    input  logic                 en1,
    input  logic signed [CW-1:0] x,
    input  logic signed [CW-1:0] y,
    input  logic signed [CW-1:0] z,
    input  logic signed [CW-1:0] m0,
    input  logic signed [CW-1:0] m1,
    input  logic signed [CW-1:0] m2,
    input  logic signed [CW-1:0] m3,
    output logic signed [CW-1:0] col_reg
);
    localparam int PW = 2 * CW;
    localparam int SW = PW - FB + 3;

    logic signed [PW-1:0] px_reg, py_reg, pz_reg;
    logic signed [CW-1:0] t_reg;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] hi_lim, lo_lim;

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (en0) begin
            px_reg <= x * m0;
            py_reg <= y * m1;
            pz_reg <= z * m2;
            t_reg  <= m3;
        end
    end

    // stage 2: floor shift, add, saturate
    always_comb begin
        sum = SW'(px_reg >>> FB) + SW'(py_reg >>> FB) + SW'(pz_reg >>> FB)
            + SW'(t_reg);
        hi_lim = SW'({1'b0, {(CW-1){1'b1}}});
        lo_lim = -hi_lim - SW'(1);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            if (sum > hi_lim)
                col_reg <= hi_lim[CW-1:0];
            else if (sum < lo_lim)
                col_reg <= lo_lim[CW-1:0];
            else
                col_reg <= sum[CW-1:0];
        end
    end
endmodule

FILE: rtl/core/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div: pipelined signed divider
// Restoring division on magnitudes, one quotient bit per stage, saturated.
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 aclk,
    input  logic [CW+FB:0]       en,
    input  logic signed [CW-1:0] num,
    input  logic signed [CW-1:0] den,
    input  logic                 bypass,
    output logic signed [CW-1:0] q_out
);
    localparam int NW = CW + FB;
    localparam int NS = NW;

    logic [NW-1:0] n_reg   [0:NS];
    logic [NW-1:0] r_reg   [0:NS];
    logic [CW-1:0] d_reg   [0:NS];
    logic [NW-1:0] q_reg   [0:NS];
    logic          neg_reg [0:NS];
    logic          byp_reg [0:NS];
    logic [CW-1:0] raw_reg [0:NS];

    logic [NW-1:0] num_mag;
    logic [CW-1:0] den_mag;

    // stage 0: magnitudes of (num << FB) and w
    always_comb begin
        num_mag = num[CW-1] ? NW'(-({{FB{num[CW-1]}}, num} <<< FB))
                            : NW'({{FB{1'b0}}, num} << FB);
        den_mag = den[CW-1] ? CW'(-den) : den;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            n_reg[0]   <= num_mag;
            r_reg[0]   <= '0;
            d_reg[0]   <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[CW-1] ^ den[CW-1];
            byp_reg[0] <= bypass;
            raw_reg[0] <= num;
        end
    end

    // one quotient bit per stage, MSB first
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_step
            logic [NW:0] trial;
            logic [NW-1:0] rs;
            always_comb begin
                rs    = {r_reg[gi][NW-2:0], n_reg[gi][NW-1-gi]};
                trial = {r_reg[gi][NW-1], rs} - (NW+1)'(d_reg[gi]);
            end
            always_ff @(posedge aclk) begin
                if (en[gi+1]) begin
                    n_reg[gi+1]   <= n_reg[gi];
                    d_reg[gi+1]   <= d_reg[gi];
                    neg_reg[gi+1] <= neg_reg[gi];
                    byp_reg[gi+1] <= byp_reg[gi];
                    raw_reg[gi+1] <= raw_reg[gi];
                    if (!trial[NW]) begin
                        r_reg[gi+1] <= trial[NW-1:0];
                        q_reg[gi+1] <= q_reg[gi] | (NW'(1) << (NW-1-gi));
                    end else begin
                        r_reg[gi+1] <= rs;
                        q_reg[gi+1] <= q_reg[gi];
                    end
                end
            end
        end
    endgenerate

    // sign and saturate
    logic [NW:0] qm;
    logic [NW:0] pos_lim;
    always_comb begin
        qm      = {1'b0, q_reg[NS]};
        pos_lim = (NW+1)'({1'b0, {(CW-1){1'b1}}});
        if (byp_reg[NS])
            q_out = raw_reg[NS];
        else if (!neg_reg[NS])
            q_out = (qm > pos_lim) ? pos_lim[CW-1:0] : qm[CW-1:0];
        else if (qm > pos_lim)
            q_out = {1'b1, {(CW-1){1'b0}}};
        else
            q_out = CW'(-qm[CW-1:0]);
    end
endmodule

FILE: verif/homogeneous_point_transform_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_checker: result scoreboard for the transform
// Tracks register writes on the APB port, predicts each output word from
// every accepted input word, and compares field by field in order.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [hpt_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [hpt_pkg::DATA_BITS-1:0]   pwdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [31:0]              s_point_x,
    input  logic signed [31:0]              s_point_y,
    input  logic signed [31:0]              s_point_z,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [31:0]              m_out_x,
    input  logic signed [31:0]              m_out_y,
    input  logic signed [31:0]              m_out_z,
    input  logic                            m_w_zero,
    output int                              fail_count,
    output int                              pending,
    output int                              words_checked,
    output int                              w_zero_seen,
    output int                              divided_seen
);
    import hpt_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        wz;
    } point_out_t;

    logic [63:0] matrix_regs [NUM_REGS];
    point_out_t  expected_points [$];

    // sign-extend the low COORD_WIDTH bits
    function automatic longint narrow(logic [63:0] v);
        logic [63:0] m;
        m = v << (64 - COORD_WIDTH);
        return $signed(m) >>> (64 - COORD_WIDTH);
    endfunction

    function automatic longint clamp(longint v);
        longint hi;
        hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint entry(int row, int col);
        logic [63:0] r;
        r = matrix_regs[row * 2 + col / 2];
        return narrow((col % 2) ? {32'd0, r[63:32]} : {32'd0, r[31:0]});
    endfunction

    // one output column: floored products, translation, saturate
    function automatic longint column_sum(longint p [3], int col);
        longint s;
        s = entry(3, col);
        for (int k = 0; k < 3; k++)
            s += (p[k] * entry(k, col)) >>> FRAC_BITS;
        return clamp(s);
    endfunction

    function automatic point_out_t transform_point(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        longint     p [3];
        longint     c [4];
        longint     one;
        longint     r;
        point_out_t res;
        one  = longint'(1) << FRAC_BITS;
        p[0] = narrow({32'd0, x});
        p[1] = narrow({32'd0, y});
        p[2] = narrow({32'd0, z});
        for (int j = 0; j < 4; j++)
            c[j] = column_sum(p, j);
        res = '0;
        if (c[3] == 0) begin
            res.wz = 1'b1;
            return res;
        end
        for (int j = 0; j < 3; j++) begin
            r = c[j];
            if (c[3] != one)
                r = clamp((r * one) / c[3]);
            c[j] = r;
        end
        res.x = c[0][31:0];
        res.y = c[1][31:0];
        res.z = c[2][31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        point_out_t want;
        if (!aresetn) begin
            matrix_regs[0] = 64'd1 << FRAC_BITS;
            matrix_regs[1] = '0;
            matrix_regs[2] = (64'd1 << FRAC_BITS) << 32;
            matrix_regs[3] = '0;
            matrix_regs[4] = '0;
            matrix_regs[5] = 64'd1 << FRAC_BITS;
            matrix_regs[6] = '0;
            matrix_regs[7] = (64'd1 << FRAC_BITS) << 32;
            expected_points.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready && paddr[ADDR_BITS-1:3] < NUM_REGS)
                matrix_regs[paddr[ADDR_BITS-1:3]] = pwdata;
            // output word first, then queue the new prediction
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t unexpected output word", $realtime);
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    words_checked++;
                    if (want.wz) w_zero_seen++;
                    else divided_seen++;
                    if (m_out_x !== want.x) report_mismatch("out_x", m_out_x, want.x);
                    if (m_out_y !== want.y) report_mismatch("out_y", m_out_y, want.y);
                    if (m_out_z !== want.z) report_mismatch("out_z", m_out_z, want.z);
                    if (m_w_zero !== want.wz)
                        report_mismatch("w_zero", {31'd0, m_w_zero}, {31'd0, want.wz});
                end
            end
            if (s_valid && s_ready)
                expected_points.push_back(transform_point(s_point_x, s_point_y, s_point_z));
        end
        pending = expected_points.size();
    end

    initial begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
        w_zero_seen   = 0;
        divided_seen  = 0;
    end
endmodule

FILE: verif/homogeneous_point_transform_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_point_transform_top_tb: stimulus and verdict for the transform
// Programs several matrices over APB, streams directed and random points
// with bursty input and stalling output, and lets the checker score results.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_top_tb;
    import hpt_pkg::*;

    localparam int LATENCY     = 3 + 32 + 16;
    localparam int CYCLE_LIMIT = 400000;

    logic                    aclk;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_BITS-1:0]    paddr;
    logic [DATA_BITS-1:0]    pwdata;
    logic [DATA_BITS-1:0]    prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [31:0]      s_point_x;
    logic signed [31:0]      s_point_y;
    logic signed [31:0]      s_point_z;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [31:0]      m_out_x;
    logic signed [31:0]      m_out_y;
    logic signed [31:0]      m_out_z;
    logic                    m_w_zero;

    int fail_count;
    int pending;
    int words_checked;
    int w_zero_seen;
    int divided_seen;
    int cycle_count;
    bit hold_off;
    int points_sent;

    homogeneous_point_transform_top uut (.*);

    homogeneous_point_transform_checker checker_i (.*);

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
            $display("homogeneous_point_transform_top_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stall pattern, or a long hold-off on request
    always @(negedge aclk) begin
        int mode;
        mode = $urandom_range(0, 9);
        if (hold_off) m_ready <= 1'b0;
        else if (mode < 3) m_ready <= 1'b1;
        else m_ready <= (mode < 8) ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_matrix(logic [63:0] m [8]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(3'(i), m[i]);
    endtask

    // one point word; valid stays up across back-to-back words
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit keep);
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        points_sent++;
        if (!keep) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic drain;
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord;
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'(int'($urandom_range(0, 512 << 16)) - (256 << 16));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_entry;
        case ($urandom_range(0, 5))
            0: return 32'h0001_0000;
            1: return 32'h0;
            2: return 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // bursty stream of random points
    task automatic random_points(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_point(rand_coord(), rand_coord(), rand_coord(),
                           i < burst - 1 && sent < count - 1);
                sent++;
            end
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    endtask

    logic [63:0] mat [8];

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_point_x   = '0;
        s_point_y   = '0;
        s_point_z   = '0;
        m_ready     = 1'b0;
        hold_off    = 1'b0;
        cycle_count = 0;
        points_sent = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // identity after reset: extremes pass through unchanged
        send_point(32'h0, 32'h0, 32'h0, 0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1);
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 0);
        drain();

        // perspective: w = x + z, and saturating sums
        mat = '{64'h0002_0000, 64'h0001_0000_0000_0000, 64'h0001_0000_0000_0000, 64'h0,
                64'h0, 64'h0001_0000_7fff_ffff, 64'h7fff_ffff_8000_0000, 64'h0};
        load_matrix(mat);
        send_point(32'h0, 32'h0, 32'h0, 0);              // w zero
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1); // w exactly one
        send_point(32'h0000_0001, 32'h1, 32'h1, 1);      // tiny w: quotient saturates
        send_point(32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000, 1);
        send_point(32'h0003_0000, 32'hfffd_0000, 32'h0002_0000, 1);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        drain();

        // w exactly one with a translation row
        mat = '{64'hffff_0000_0001_0000, 64'h0, 64'h0001_0000_ffff_0000, 64'h0,
                64'h0, 64'h0000_0000_0002_0000, 64'h8000_0000_7fff_ffff,
                64'h0001_0000_0000_8000};
        load_matrix(mat);
        for (int i = 0; i < 6; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i < 5);
        drain();

        // random matrices, each with a random stream
        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < NUM_REGS; i++)
                mat[i] = {rand_entry(), rand_entry()};
            // keep w away from zero most of the time
            if (phase % 2 == 0) mat[7] = {32'h0001_0000, mat[7][31:0]};
            load_matrix(mat);
            if (phase == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                    random_points(120);
                join
            end else
                random_points(120);
            drain();
        end

        $display("%0d points sent over 9 matrix settings, %0d results checked",
                 points_sent, words_checked);
        $display("%0d results with w zero, %0d with a nonzero w", w_zero_seen, divided_seen);
        if (fail_count == 0)
            $display("homogeneous_point_transform_top_tb: done, clean");
        else
            $display("homogeneous_point_transform_top_tb: done, errors");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_col.sv
rtl/core/hpt_div.sv
rtl/core/homogeneous_point_transform_top.sv
verif/homogeneous_point_transform_checker.sv
verif/homogeneous_point_transform_top_tb.sv
